// ===== rtl/overlapping_grid_cell_binner_core_defines.svh =====
// assertion macros for the overlapping grid cell binner
// no dependencies; included by ogcb_back, the only module that carries assertions
`ifndef OVERLAPPING_GRID_CELL_BINNER_CORE_DEFINES_SVH
`define OVERLAPPING_GRID_CELL_BINNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define OGCB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ogcb assertion failed");
`define OGCB_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ogcb forbidden condition seen");
`else
`define OGCB_ASSERT(label, clk, rst, prop)
`define OGCB_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== rtl/ogcb_pkg.sv =====
// shared constants, codes and types of the overlapping grid cell binner
// no dependencies
package ogcb_pkg;

   localparam int GRID_DIM_DEF = 1024;
   localparam int COORD_W      = 32;
   localparam int SIZE_W       = 31;
   localparam int CELL_W       = 10;
   localparam int KIND_W       = 2;
   localparam int IDX_W        = 2;
   localparam int FIFO_DEPTH   = 2;

   localparam logic [IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
   localparam logic [IDX_W-1:0] REG_ORIGIN_Y  = 2'd1;
   localparam logic [IDX_W-1:0] REG_CELL_SIZE = 2'd2;
   localparam logic [IDX_W-1:0] REG_OVERLAP   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_HOME  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

   localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 31'd65536;
   localparam logic [SIZE_W-1:0] OVERLAP_RST   = 31'd6554;

   // grid geometry as seen by front and back
   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] step;
      logic [SIZE_W-1:0]  overlap;
   } geom_type;

   // non-negative offsets of a point that may land in the grid
   typedef struct packed {
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
   } entry_type;

endpackage

// ===== rtl/ogcb_front.sv =====
// front end: takes points, forms grid offsets and drops non-finite points and points sure to reach no cell
// depends on ogcb_pkg
module ogcb_front #(
   parameter int GRID_DIM = ogcb_pkg::GRID_DIM_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,   // point_x [31:0], point_y [63:32]
   input  logic [0:0]          req_tuser,   // finite [0]
   input  ogcb_pkg::geom_type  geom,
   output logic                push_valid,
   input  logic                push_ready,
   output ogcb_pkg::entry_type push_data
);

   localparam int QB = $clog2(GRID_DIM) + 1;
   localparam int W  = ogcb_pkg::SIZE_W + QB;

   logic        s_valid_ff;
   logic [32:0] dx_ff, dx_in;
   logic [32:0] dy_ff, dy_in;
   logic [W-1:0] limit, dx_w, dy_w;
   logic        step_pos, keep, advance, accept;

   assign dx_in = {req_tdata[31], req_tdata[31:0]}
                - {geom.origin_x[31], geom.origin_x};
   assign dy_in = {req_tdata[63], req_tdata[63:32]}
                - {geom.origin_y[31], geom.origin_y};

   assign step_pos = !geom.step[31] && (geom.step != '0);
   assign limit    = {geom.step[30:0], {QB{1'b0}}};
   assign dx_w     = {{(W-32){1'b0}}, dx_ff[31:0]};
   assign dy_w     = {{(W-32){1'b0}}, dy_ff[31:0]};

   // negative offsets, offsets of 2**QB steps or more and a step that is not positive give no cell
   assign keep = step_pos && !dx_ff[32] && !dy_ff[32] && (dx_w < limit) && (dy_w < limit);

   assign push_valid   = s_valid_ff && keep;
   assign push_data.dx = dx_ff[31:0];
   assign push_data.dy = dy_ff[31:0];

   assign advance    = !s_valid_ff || !keep || push_ready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (advance) begin
         s_valid_ff <= accept && req_tuser[0];
      end
      if (advance && accept) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

endmodule

// ===== rtl/ogcb_fifo.sv =====
// short item queue between the front end and the divide and emit back end
// depends on ogcb_pkg
module ogcb_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ogcb_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ogcb_pkg::entry_type pop_data
);

   localparam int DEPTH = ogcb_pkg::FIFO_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   ogcb_pkg::entry_type mem [DEPTH];

   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   assign wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
   assign rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wptr_ff <= wptr_in;
         end
         if (do_pop) begin
            rptr_ff <= rptr_in;
         end
      end
      if (do_push) begin
         mem[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/ogcb_back.sv =====
// back end: restoring floor division of both offsets, then emits home, left and lower cells
// depends on ogcb_pkg and the assertion macro header
`include "overlapping_grid_cell_binner_core_defines.svh"

module ogcb_back #(
   parameter int GRID_DIM = ogcb_pkg::GRID_DIM_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  ogcb_pkg::entry_type pop_data,
   input  ogcb_pkg::geom_type  geom,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // cell_col [9:0], cell_row [19:10]
   output logic [1:0]          rsp_tuser,   // copy_kind [1:0]
   output logic                rsp_tlast
);

   localparam int QB     = $clog2(GRID_DIM) + 1;
   localparam int W      = ogcb_pkg::SIZE_W + QB;
   localparam int CW     = $clog2(QB);
   localparam int CELL_W = ogcb_pkg::CELL_W;
   localparam logic [QB-1:0] GRID_Q = QB'(GRID_DIM);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EVAL, ST_EMIT} state_type;

   state_type   state_ff;
   logic [CW-1:0] cnt_ff;
   logic [31:0] remx_ff, remy_ff, remx_in, remy_in;
   logic [W-1:0] div_ff, div_init, remx_w, remy_w, subx, suby;
   logic [QB-1:0] qx_ff, qy_ff;
   logic [2:0]  pend_ff, pend_in, rest;
   logic        bit_x, bit_y;
   logic        cx_in, cy_in, cxm1_in, cym1_in, rx_small, ry_small;
   logic        out_free;
   logic        div_ok;
   logic        rsp_valid_ff, last_ff;
   logic [CELL_W-1:0] col_ff, row_ff, col_in, row_in;
   logic [ogcb_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [QB-1:0] col_q, row_q;
   logic [QB+CELL_W-1:0] col_x, row_x;

   assign pop_ready = (state_ff == ST_IDLE);
   assign div_init  = {1'b0, geom.step[30:0], {(QB-1){1'b0}}};

   // one quotient bit per axis each cycle
   assign remx_w  = {{(W-32){1'b0}}, remx_ff};
   assign remy_w  = {{(W-32){1'b0}}, remy_ff};
   assign bit_x   = (remx_w >= div_ff);
   assign bit_y   = (remy_w >= div_ff);
   assign subx    = remx_w - div_ff;
   assign suby    = remy_w - div_ff;
   assign remx_in = bit_x ? subx[31:0] : remx_ff;
   assign remy_in = bit_y ? suby[31:0] : remy_ff;
   assign div_ok  = ({1'b0, remx_w} < {div_ff, 1'b0}) && ({1'b0, remy_w} < {div_ff, 1'b0});

   assign cx_in    = (qx_ff < GRID_Q);
   assign cy_in    = (qy_ff < GRID_Q);
   assign cxm1_in  = (qx_ff != '0) && (qx_ff <= GRID_Q);
   assign cym1_in  = (qy_ff != '0) && (qy_ff <= GRID_Q);
   assign rx_small = (remx_ff < {1'b0, geom.overlap});
   assign ry_small = (remy_ff < {1'b0, geom.overlap});
   assign pend_in  = {ry_small && cx_in && cym1_in,
                      rx_small && cxm1_in && cy_in,
                      cx_in && cy_in};

   // pick the lowest pending copy
   always_comb begin
      col_q   = qx_ff;
      row_q   = qy_ff;
      kind_in = ogcb_pkg::KIND_HOME;
      rest    = pend_ff;
      if (pend_ff[0]) begin
         rest[0] = 1'b0;
      end else if (pend_ff[1]) begin
         col_q   = qx_ff - 1'b1;
         kind_in = ogcb_pkg::KIND_LEFT;
         rest[1] = 1'b0;
      end else begin
         row_q   = qy_ff - 1'b1;
         kind_in = ogcb_pkg::KIND_LOWER;
         rest[2] = 1'b0;
      end
   end

   assign col_x    = {{CELL_W{1'b0}}, col_q};
   assign row_x    = {{CELL_W{1'b0}}, row_q};
   assign col_in   = col_x[CELL_W-1:0];
   assign row_in   = row_x[CELL_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  remx_ff  <= pop_data.dx;
                  remy_ff  <= pop_data.dy;
                  div_ff   <= div_init;
                  cnt_ff   <= CW'(QB - 1);
                  qx_ff    <= '0;
                  qy_ff    <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               remx_ff <= remx_in;
               remy_ff <= remy_in;
               qx_ff   <= {qx_ff[QB-2:0], bit_x};
               qy_ff   <= {qy_ff[QB-2:0], bit_y};
               div_ff  <= div_ff >> 1;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               pend_ff  <= pend_in;
               state_ff <= (pend_in == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  col_ff       <= col_in;
                  row_ff       <= row_in;
                  kind_ff      <= kind_in;
                  last_ff      <= (rest == '0);
                  pend_ff      <= rest;
                  if (rest == '0) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, row_ff, col_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   `OGCB_ASSERT(a_pend_only_in_emit, clock, reset, (state_ff == ST_EMIT) == (pend_ff != 3'b000))
   `OGCB_ASSERT(a_div_bound, clock, reset, state_ff == ST_DIV |-> div_ok)
   `OGCB_ASSERT_NEVER(a_nonlast_exit, clock, reset, rsp_tvalid && !rsp_tlast && state_ff != ST_EMIT)

endmodule

// ===== rtl/overlapping_grid_cell_binner_core.sv =====
// the back end takes a new point only from idle, once the shared one-bit-per-cycle divider of
// the back end has finished the last point and all its cells (0 to 3) have been given out;
// points that the front end drops never reach the divider
// reset: synchronous, active high; registers return to origin 0, cell size 1.0, overlap 0.1
// top level: register port, front end, item queue and back end; depends on ogcb_pkg
module overlapping_grid_cell_binner_core #(
   parameter int GRID_DIM = ogcb_pkg::GRID_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x [31:0], point_y [63:32]
   input  logic [0:0]  req_tuser,   // finite [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // cell_col [9:0], cell_row [19:10]
   output logic [1:0]  rsp_tuser,   // copy_kind [1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] origin_x_ff, origin_y_ff, step_ff;
   logic [30:0] cell_size_ff, overlap_ff;
   logic        csr_write;

   ogcb_pkg::geom_type  geom;
   ogcb_pkg::entry_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         cell_size_ff <= ogcb_pkg::CELL_SIZE_RST;
         overlap_ff   <= ogcb_pkg::OVERLAP_RST;
         step_ff      <= {1'b0, ogcb_pkg::CELL_SIZE_RST} - {1'b0, ogcb_pkg::OVERLAP_RST};
      end else begin
         step_ff <= {1'b0, cell_size_ff} - {1'b0, overlap_ff};
         if (csr_write) begin
            case (csr_index)
               ogcb_pkg::REG_ORIGIN_X:  origin_x_ff  <= csr_data;
               ogcb_pkg::REG_ORIGIN_Y:  origin_y_ff  <= csr_data;
               ogcb_pkg::REG_CELL_SIZE: cell_size_ff <= csr_data[30:0];
               ogcb_pkg::REG_OVERLAP:   overlap_ff   <= csr_data[30:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign geom.origin_x = origin_x_ff;
   assign geom.origin_y = origin_y_ff;
   assign geom.step     = step_ff;
   assign geom.overlap  = overlap_ff;

   ogcb_front #(.GRID_DIM(GRID_DIM)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .geom       (geom),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ogcb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ogcb_back #(.GRID_DIM(GRID_DIM)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .geom       (geom),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
